@@ rtl/sbp_pkg.sv @@
`timescale 1ns / 1ps

package sbp_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int MAX_SAMPLES  = 262144;

  // Byte stride of one channel's block inside a coefficient chunk.
  localparam int COEF_STRIDE  = 46;
  // Bytes of a channel block that hold its sixteen coefficients.
  localparam int COEF_BYTES   = 32;

  localparam int HDR_BYTES    = 8;
  localparam int CHUNK_BYTES  = 4;

  localparam logic [6:0] CHUNK_NONE     = 7'd0;
  localparam logic [6:0] CHUNK_CHANNELS = 7'd1;
  localparam logic [6:0] CHUNK_RATE     = 7'd2;
  localparam logic [6:0] CHUNK_COEFS    = 7'd7;

  localparam logic REC_SAMPLE = 1'b0;
  localparam logic REC_COEF   = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_CHUNK_HEAD,
    PH_CHUNK_BODY,
    PH_DONE
  } phase_e;

  typedef enum logic [0:0] {
    CFG_SAMPLE_COUNT = 1'b0,
    CFG_REGION_BYTES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [18:0] sample_count;
    logic [31:0] header_region_bytes;
  } cfg_t;

  typedef struct packed {
    logic               record_kind;
    logic [17:0]        sample_number;
    logic [29:0]        frame_count;
    logic [31:0]        sample_rate;
    logic [7:0]         channel_count;
    logic [31:0]        data_offset;
    logic               has_coefficients;
    logic [2:0]         coef_channel;
    logic [3:0]         coef_position;
    logic signed [15:0] coef_value;
    logic               last_record;
  } result_t;

  function automatic logic [31:0] rate_lookup(logic [3:0] idx);
    logic [31:0] rate;
    case (idx)
      4'd0:    rate = 32'd4000;
      4'd1:    rate = 32'd8000;
      4'd2:    rate = 32'd11000;
      4'd3:    rate = 32'd11025;
      4'd4:    rate = 32'd16000;
      4'd5:    rate = 32'd22050;
      4'd6:    rate = 32'd24000;
      4'd7:    rate = 32'd32000;
      4'd8:    rate = 32'd44100;
      4'd9:    rate = 32'd48000;
      default: rate = 32'd0;
    endcase
    return rate;
  endfunction

endpackage

@@ rtl/sbp_intf.sv @@
`timescale 1ns / 1ps

interface sbp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_bank;

  modport source (output valid, output data_byte, output start_of_bank, input ready);
  modport sink   (input valid, input data_byte, input start_of_bank, output ready);
endinterface

interface sbp_out_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic [17:0]        sample_number;
  logic [29:0]        frame_count;
  logic [31:0]        sample_rate;
  logic [7:0]         channel_count;
  logic [31:0]        data_offset;
  logic               has_coefficients;
  logic [2:0]         coef_channel;
  logic [3:0]         coef_position;
  logic signed [15:0] coef_value;
  logic               last_record;

  modport source (
    output valid, output record_kind, output sample_number, output frame_count,
    output sample_rate, output channel_count, output data_offset,
    output has_coefficients, output coef_channel, output coef_position,
    output coef_value, output last_record, input ready
  );
  modport sink (
    input valid, input record_kind, input sample_number, input frame_count,
    input sample_rate, input channel_count, input data_offset,
    input has_coefficients, input coef_channel, input coef_position,
    input coef_value, input last_record, output ready
  );
endinterface

interface sbp_cfg_if import sbp_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_reg_e    index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/sbp_core.sv @@
`timescale 1ns / 1ps

module sbp_core import sbp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       start_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [18:0] count_q, count_d;
  logic [23:0] ebc_q, ebc_d;
  logic [55:0] asm_q, asm_d;
  logic [29:0] frames_q, frames_d;
  logic [31:0] rate_q, rate_d;
  logic [7:0]  chans_q, chans_d;
  logic [31:0] offset_q, offset_d;
  logic        coef_flag_q, coef_flag_d;
  logic        more_q, more_d;
  logic [6:0]  kind_q, kind_d;
  logic [23:0] len_q, len_d;
  logic [3:0]  cch_q, cch_d;
  logic [5:0]  cb_q, cb_d;

  // Current state, with a start mark clearing it before the byte is parsed.
  logic        clr;
  phase_e      phase_c;
  logic [31:0] pos_c;
  logic [18:0] count_c;
  logic [23:0] ebc_c, ebc_inc;
  logic [55:0] asm_c;
  logic [7:0]  chans_c;
  logic [23:0] len_c;
  logic [3:0]  cch_c;
  logic [5:0]  cb_c;

  logic signed [33:0] room;
  logic [63:0] word;
  logic [55:0] asm_base;
  logic [2:0]  shift_sel;
  logic [31:0] chunk_word;
  logic [9:0]  coef_need;
  logic        bad_count, last;
  logic        do_after, do_end, coef_fire;
  logic [15:0] coef_val;

  always_comb begin
    clr     = step_i && start_i;
    phase_c = clr ? PH_HEADER : phase_q;
    pos_c   = clr ? '0 : pos_q;
    count_c = clr ? '0 : count_q;
    ebc_c   = clr ? '0 : ebc_q;
    asm_c   = clr ? '0 : asm_q;
    chans_c = clr ? '0 : chans_q;
    len_c   = clr ? '0 : len_q;
    cch_c   = clr ? '0 : cch_q;
    cb_c    = clr ? '0 : cb_q;

    phase_d     = phase_c;
    pos_d       = pos_c;
    count_d     = count_c;
    ebc_d       = ebc_c;
    asm_d       = asm_c;
    frames_d    = clr ? '0 : frames_q;
    rate_d      = clr ? '0 : rate_q;
    chans_d     = chans_c;
    offset_d    = clr ? '0 : offset_q;
    coef_flag_d = clr ? 1'b0 : coef_flag_q;
    more_d      = clr ? 1'b0 : more_q;
    kind_d      = clr ? '0 : kind_q;
    len_d       = len_c;
    cch_d       = cch_c;
    cb_d        = cb_c;

    // Bytes left in the region before this byte; negative after a shrink.
    room = $signed({2'b00, cfg_i.header_region_bytes}) - $signed({2'b00, pos_c});
    ebc_inc = ebc_c + 24'd1;

    bad_count = (cfg_i.sample_count == '0)
             || (32'(cfg_i.sample_count) > 32'(MAX_SAMPLES))
             || (count_c >= cfg_i.sample_count)
             || (room < 34'sd8);

    asm_base  = ((phase_c == PH_HEADER) && (ebc_c == '0)) ? '0 : asm_c;
    shift_sel = (phase_c == PH_HEADER) ? ebc_c[2:0] : {1'b0, ebc_c[1:0]};
    word      = {8'h00, asm_base} | ({56'h0, data_byte_i} << {shift_sel, 3'b000});
    chunk_word = word[31:0];
    coef_need = 10'(COEF_STRIDE) * {6'b0, chans_c[3:0]};
    coef_val  = {asm_c[7:0], data_byte_i};

    do_after  = 1'b0;
    do_end    = 1'b0;
    coef_fire = 1'b0;

    if (step_i) begin
      unique case (phase_c)
        PH_HEADER: begin
          if ((ebc_c == '0) && bad_count) begin
            phase_d = PH_DONE;
          end else begin
            asm_d = word[55:0];
            ebc_d = ebc_inc;
            pos_d = pos_c + 32'd1;
            if (ebc_c[2:0] == 3'(HDR_BYTES - 1)) begin
              frames_d    = word[63:34];
              rate_d      = rate_lookup(word[4:1]);
              chans_d     = {7'b0, word[5]} + 8'd1;
              offset_d    = {word[33:6], 4'b0000};
              coef_flag_d = 1'b0;
              more_d      = word[0];
              do_after    = 1'b1;
            end
          end
        end
        PH_CHUNK_HEAD: begin
          asm_d = word[55:0];
          ebc_d = ebc_inc;
          pos_d = pos_c + 32'd1;
          if (ebc_c[1:0] == 2'(CHUNK_BYTES - 1)) begin
            ebc_d  = '0;
            asm_d  = '0;
            more_d = chunk_word[0];
            len_d  = chunk_word[24:1];
            kind_d = chunk_word[31:25];
            if (room < $signed({10'b0, chunk_word[24:1]} + 34'd1)) begin
              do_end = 1'b1;
            end else begin
              if (chunk_word[31:25] == CHUNK_RATE) begin
                if (chunk_word[24:1] < 24'd4) kind_d = CHUNK_NONE;
              end else if (chunk_word[31:25] == CHUNK_COEFS) begin
                if ((chans_c <= 8'(MAX_CHANNELS))
                    && ({14'b0, coef_need} <= chunk_word[24:1])) begin
                  coef_flag_d = 1'b1;
                end else begin
                  kind_d = CHUNK_NONE;
                end
              end else if (chunk_word[31:25] != CHUNK_CHANNELS) begin
                kind_d = CHUNK_NONE;
              end
              cch_d = '0;
              cb_d  = '0;
              if (chunk_word[24:1] == '0) do_after = 1'b1;
              else phase_d = PH_CHUNK_BODY;
            end
          end
        end
        PH_CHUNK_BODY: begin
          if (kind_q == CHUNK_CHANNELS) begin
            if (ebc_c == '0) chans_d = data_byte_i;
          end else if (kind_q == CHUNK_RATE) begin
            if (ebc_c < 24'd4) asm_d = word[55:0];
            if (ebc_c == 24'd3) rate_d = chunk_word;
          end else if ((kind_q == CHUNK_COEFS) && ({4'b0, cch_c} < chans_c)) begin
            if (cb_c < 6'(COEF_BYTES)) begin
              if (cb_c[0]) coef_fire = 1'b1;
              else asm_d = {48'h0, data_byte_i};
            end
            if (cb_c == 6'(COEF_STRIDE - 1)) begin
              cb_d  = '0;
              cch_d = cch_c + 4'd1;
            end else begin
              cb_d = cb_c + 6'd1;
            end
          end
          ebc_d = ebc_inc;
          pos_d = pos_c + 32'd1;
          if (ebc_inc >= len_c) do_after = 1'b1;
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    // Chunk chain continues only while the next chunk header still fits.
    if (do_after) begin
      ebc_d = '0;
      asm_d = '0;
      if (more_d && (room >= 34'sd5)) phase_d = PH_CHUNK_HEAD;
      else do_end = 1'b1;
    end

    last = ({1'b0, count_c} + 20'd1 >= {1'b0, cfg_i.sample_count}) || (room < 34'sd9);

    res_o       = '0;
    res_valid_o = 1'b0;
    res_o.sample_number = count_c[17:0];
    if (do_end) begin
      res_valid_o            = 1'b1;
      res_o.record_kind      = REC_SAMPLE;
      res_o.frame_count      = frames_d;
      res_o.sample_rate      = rate_d;
      res_o.channel_count    = chans_d;
      res_o.data_offset      = offset_d;
      res_o.has_coefficients = coef_flag_d;
      res_o.last_record      = last;
      count_d = count_c + 19'd1;
      phase_d = last ? PH_DONE : PH_HEADER;
      ebc_d   = '0;
      asm_d   = '0;
    end else if (coef_fire && !do_after) begin
      // A coefficient that completes on a chunk's final byte is dropped.
      res_valid_o         = 1'b1;
      res_o.record_kind   = REC_COEF;
      res_o.coef_channel  = cch_c[2:0];
      res_o.coef_position = cb_c[4:1];
      res_o.coef_value    = $signed(coef_val);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      pos_q       <= '0;
      count_q     <= '0;
      ebc_q       <= '0;
      asm_q       <= '0;
      frames_q    <= '0;
      rate_q      <= '0;
      chans_q     <= '0;
      offset_q    <= '0;
      coef_flag_q <= 1'b0;
      more_q      <= 1'b0;
      kind_q      <= '0;
      len_q       <= '0;
      cch_q       <= '0;
      cb_q        <= '0;
    end else begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      ebc_q       <= ebc_d;
      asm_q       <= asm_d;
      frames_q    <= frames_d;
      rate_q      <= rate_d;
      chans_q     <= chans_d;
      offset_q    <= offset_d;
      coef_flag_q <= coef_flag_d;
      more_q      <= more_d;
      kind_q      <= kind_d;
      len_q       <= len_d;
      cch_q       <= cch_d;
      cb_q        <= cb_d;
    end
  end

endmodule

@@ rtl/sbp_out_buf.sv @@
`timescale 1ns / 1ps

module sbp_out_buf import sbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  result_t   res_i,
  output logic      can_push_o,
  sbp_out_if.source out_o
);

  logic    valid_q;
  result_t res_q;

  // The register may be refilled in the same cycle its request is taken.
  assign can_push_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_push_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_push_o && push_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid            = valid_q;
  assign out_o.record_kind      = res_q.record_kind;
  assign out_o.sample_number    = res_q.sample_number;
  assign out_o.frame_count      = res_q.frame_count;
  assign out_o.sample_rate      = res_q.sample_rate;
  assign out_o.channel_count    = res_q.channel_count;
  assign out_o.data_offset      = res_q.data_offset;
  assign out_o.has_coefficients = res_q.has_coefficients;
  assign out_o.coef_channel     = res_q.coef_channel;
  assign out_o.coef_position    = res_q.coef_position;
  assign out_o.coef_value       = res_q.coef_value;
  assign out_o.last_record      = res_q.last_record;

endmodule

@@ rtl/sound_bank_v5_header_parser_top.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Carries
// in_i      sink       data_byte, start_of_bank: one region byte per request
// out_o     source     sample records and coefficient items, at most one per byte
// cfg_i     sink       index, data: register writes, always ready
//
// One byte is taken every cycle while out_o does not stall; a byte's result goes from the
// input register, through the parse logic, into the output register that drives out_o.
// Reset clears the parse state, the sample count to 1 and the region length to 0.
// A stall on out_o holds the byte in the input register, and in_i drops ready
// only once both the input and the output register are occupied.

module sound_bank_v5_header_parser_top import sbp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sbp_in_if.sink    in_i,
  sbp_out_if.source out_o,
  sbp_cfg_if.sink   cfg_i
);

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       start_q;
  logic       can_push;
  logic       step;
  logic       res_valid;
  result_t    res;
  cfg_t       cfg_q;

  assign in_i.ready  = !in_valid_q || can_push;
  assign cfg_i.ready = 1'b1;
  assign step        = in_valid_q && can_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q  <= in_i.data_byte;
      start_q <= in_i.start_of_bank;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_count        <= 19'd1;
      cfg_q.header_region_bytes <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_SAMPLE_COUNT: cfg_q.sample_count        <= cfg_i.data[18:0];
        CFG_REGION_BYTES: cfg_q.header_region_bytes <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  sbp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .data_byte_i (byte_q),
    .start_i     (start_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sbp_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (step && res_valid),
    .res_i      (res),
    .can_push_o (can_push),
    .out_o      (out_o)
  );

endmodule
